// ===== rtl/gwm_pkg.sv =====
// Package for the glob wildcard matcher: capacities, derived widths,
// wildcard byte codes, request codes and sequencer states.
// No dependencies.
package gwm_pkg;

  localparam int unsigned MAX_PATTERN = 32;
  localparam int unsigned MAX_TARGET  = 64;

  // Address widths index the stores; length widths also hold the full count.
  localparam int unsigned PAT_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned PAT_LW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned TGT_AW = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
  localparam int unsigned TGT_LW = $clog2(MAX_TARGET + 1);

  localparam logic [7:0] CH_ANY_ONE = 8'h3F;  // '?'
  localparam logic [7:0] CH_ANY_RUN = 8'h2A;  // '*'

  typedef enum logic [1:0] {
    REQ_CLR_PAT = 2'd0,
    REQ_ADD_PAT = 2'd1,
    REQ_ADD_TGT = 2'd2,
    REQ_EVAL    = 2'd3
  } gwm_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_TAIL,
    ST_RESP
  } gwm_state_e;

endpackage

// ===== rtl/glob_wildcard_matcher_unit.sv =====
// Top level of the glob wildcard matcher: request decode, pattern and target
// stores, the backtracking match sequencer and the result register.
// Depends on gwm_pkg and gwm_ram.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid_i, in_ready_o, req_type_i,       | in
//          | char_value_i                              |
//  verdict | out_valid_o, out_ready_i, matched_o,      | out
//          | overflow_o                                |
//
// Clear and append transactions are handled in ST_IDLE. An evaluate
// transaction walks the stores through one compare unit fed by the two RAM
// read ports: each match step is a fetch state (ST_FETCH) followed by a
// compare state (ST_EVAL or ST_TAIL); steps grow with backtracking up to
// roughly pattern length times target length. Overflow skips to ST_RESP.
// Reset (rst_ni low, asynchronous) empties pattern and target and clears the
// overflow flags; store contents stay undefined until written.
// in_ready_o is high only while the sequencer is idle. A finished verdict
// waits in the output register; a further verdict waits in ST_RESP until
// that register is free.
module glob_wildcard_matcher_unit
  import gwm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] char_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       matched_o,
  output logic       overflow_o
);

  gwm_state_e state_q, state_d;

  // Store fill levels and overflow flags.
  logic [PAT_LW-1:0] plen_q, plen_d;
  logic              povf_q, povf_d;
  logic [TGT_LW-1:0] tlen_q, tlen_d;
  logic              tovf_q, tovf_d;

  // Match cursors: p/t current, rp/rt resume point after the last star.
  logic [PAT_LW-1:0] p_q, p_d, rp_q, rp_d;
  logic [TGT_LW-1:0] t_q, t_d, rt_q, rt_d;
  logic              star_q, star_d;

  // Pending verdict and output register.
  logic res_match_q, res_match_d;
  logic res_ovf_q, res_ovf_d;
  logic out_valid_q, out_valid_d;
  logic matched_q, overflow_q;

  logic       in_fire;
  gwm_req_e   req;
  logic       pat_we, tgt_we;
  logic [7:0] pat_rd, tgt_rd;
  logic       t_more, p_more, pc_star, pc_hit, out_free;

  assign req      = gwm_req_e'(req_type_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign pat_we = in_fire && (req == REQ_ADD_PAT) && (plen_q < PAT_LW'(MAX_PATTERN));
  assign tgt_we = in_fire && (req == REQ_ADD_TGT) && (tlen_q < TGT_LW'(MAX_TARGET));

  gwm_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PATTERN)
  ) u_pat_ram (
    .clk_i  (clk_i),
    .we_i   (pat_we),
    .waddr_i(plen_q[PAT_AW-1:0]),
    .wdata_i(char_value_i),
    .raddr_i(p_q[PAT_AW-1:0]),
    .rdata_o(pat_rd)
  );

  gwm_ram #(
    .WIDTH(8),
    .DEPTH(MAX_TARGET)
  ) u_tgt_ram (
    .clk_i  (clk_i),
    .we_i   (tgt_we),
    .waddr_i(tlen_q[TGT_AW-1:0]),
    .wdata_i(char_value_i),
    .raddr_i(t_q[TGT_AW-1:0]),
    .rdata_o(tgt_rd)
  );

  // Shared compare unit. p/t are held through ST_EVAL and ST_TAIL, so the
  // cursor compares still describe the bytes just read.
  assign t_more  = (t_q < tlen_q);
  assign p_more  = (p_q < plen_q);
  assign pc_star = p_more && (pat_rd == CH_ANY_RUN);
  assign pc_hit  = p_more && ((pat_rd == CH_ANY_ONE) || (pat_rd == tgt_rd));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (req == REQ_EVAL)) begin
          state_d = (povf_q || tovf_q) ? ST_RESP : ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (t_more) begin
          state_d = ST_EVAL;
        end else if (p_more) begin
          state_d = ST_TAIL;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_EVAL: begin
        if (pc_star || pc_hit || star_q) begin
          state_d = ST_FETCH;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_TAIL: begin
        state_d = pc_star ? ST_FETCH : ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    plen_d      = plen_q;
    povf_d      = povf_q;
    tlen_d      = tlen_q;
    tovf_d      = tovf_q;
    p_d         = p_q;
    t_d         = t_q;
    rp_d        = rp_q;
    rt_d        = rt_q;
    star_d      = star_q;
    res_match_d = res_match_q;
    res_ovf_d   = res_ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (req)
            REQ_CLR_PAT: begin
              plen_d = '0;
              povf_d = 1'b0;
            end
            REQ_ADD_PAT: begin
              if (pat_we) begin
                plen_d = plen_q + PAT_LW'(1);
              end else begin
                povf_d = 1'b1;
              end
            end
            REQ_ADD_TGT: begin
              if (tgt_we) begin
                tlen_d = tlen_q + TGT_LW'(1);
              end else begin
                tovf_d = 1'b1;
              end
            end
            REQ_EVAL: begin
              p_d         = '0;
              t_d         = '0;
              rp_d        = '0;
              rt_d        = '0;
              star_d      = 1'b0;
              res_match_d = 1'b0;
              res_ovf_d   = povf_q || tovf_q;
            end
          endcase
        end
      end
      ST_FETCH: begin
        // Target and pattern both used up: whole-string match.
        if (!t_more && !p_more) begin
          res_match_d = 1'b1;
        end
      end
      ST_EVAL: begin
        priority if (pc_star) begin
          star_d = 1'b1;
          p_d    = p_q + PAT_LW'(1);
          rp_d   = p_q + PAT_LW'(1);
          rt_d   = t_q;
        end else if (pc_hit) begin
          p_d = p_q + PAT_LW'(1);
          t_d = t_q + TGT_LW'(1);
        end else if (star_q) begin
          // Let the last star swallow one more target byte.
          rt_d = rt_q + TGT_LW'(1);
          t_d  = rt_q + TGT_LW'(1);
          p_d  = rp_q;
        end else begin
          res_match_d = 1'b0;
        end
      end
      ST_TAIL: begin
        // Only trailing stars may remain once the target is consumed.
        if (pc_star) begin
          p_d = p_q + PAT_LW'(1);
        end else begin
          res_match_d = 1'b0;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          tlen_d = '0;
          tovf_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || ((state_q == ST_RESP) && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      plen_q      <= '0;
      povf_q      <= 1'b0;
      tlen_q      <= '0;
      tovf_q      <= 1'b0;
      star_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plen_q      <= plen_d;
      povf_q      <= povf_d;
      tlen_q      <= tlen_d;
      tovf_q      <= tovf_d;
      star_q      <= star_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    t_q         <= t_d;
    rp_q        <= rp_d;
    rt_q        <= rt_d;
    res_match_q <= res_match_d;
    res_ovf_q   <= res_ovf_d;
    if ((state_q == ST_RESP) && out_free) begin
      matched_q  <= res_match_q && !res_ovf_q;
      overflow_q <= res_ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;
  assign overflow_o  = overflow_q;

  // Overflow verdicts never report a match.
  a_ovf_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && overflow_q |-> !matched_q)
    else $error("overflow verdict reports a match");

  // Cursors stay inside the stored strings while matching.
  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH || state_q == ST_EVAL || state_q == ST_TAIL)
      |-> (p_q <= plen_q) && (t_q <= tlen_q))
    else $error("match cursor beyond string length");

  // Resume point never runs ahead of the live cursors.
  a_resume_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    star_q && (state_q == ST_FETCH || state_q == ST_EVAL)
      |-> (rt_q <= t_q) && (rp_q <= p_q))
    else $error("backtrack point ahead of cursor");

  // A new verdict is only loaded from the response state.
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("verdict issued outside response state");

  // Target store is emptied once its verdict is handed off.
  a_tgt_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) && out_free |=> (tlen_q == '0) && !tovf_q)
    else $error("target not cleared after verdict");

endmodule

// ===== rtl/gwm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gwm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
